// ===== rtl/prcr_pkg.sv =====
// Package for the priority command reschedule controller.
// Holds the phase enum, command, outcome, status and register codes, and the channel payloads.
// No dependencies.
package prcr_pkg;

    localparam int TAG_BITS = 16;
    localparam int SERIAL_BITS = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 8;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_BOUNDARY = 2'd1,
        PH_RETRY    = 2'd2
    } t_phase;

    localparam logic [1:0] CMD_REQUEST  = 2'd0;
    localparam logic [1:0] CMD_BOUNDARY = 2'd1;
    localparam logic [1:0] CMD_RETRY    = 2'd2;

    localparam logic [1:0] OUTCOME_SUCCESS   = 2'd0;
    localparam logic [1:0] OUTCOME_RETRYABLE = 2'd1;

    localparam logic [2:0] ST_ACCEPTED  = 3'd0;
    localparam logic [2:0] ST_INVALID   = 3'd1;
    localparam logic [2:0] ST_BUSY      = 3'd2;
    localparam logic [2:0] ST_SCHEDULED = 3'd3;
    localparam logic [2:0] ST_RETRY     = 3'd4;
    localparam logic [2:0] ST_FAILED    = 3'd5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GATEWAY_ENABLED       = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_SCHEDULE_ATTEMPTS = 1'd1;

    localparam logic [7:0] MAX_ATTEMPTS_RESET = 8'd3;
    localparam logic [7:0] ATTEMPT_SAT        = 8'hFF;
    localparam logic [SERIAL_BITS-1:0] SERIAL_HALF = 32'h8000_0000;

    typedef struct packed {
        logic [1:0]             command;
        logic [TAG_BITS-1:0]    work_tag;
        logic [SERIAL_BITS-1:0] cutoff_serial;
        logic [1:0]             schedule_outcome;
    } t_cmd;

    typedef struct packed {
        logic [2:0]             status;
        logic                   abort_request;
        logic                   abort_clear;
        logic                   reschedule_issued;
        logic                   failure_valid;
        logic [SERIAL_BITS-1:0] failure_generation;
        logic [SERIAL_BITS-1:0] failure_cutoff;
        logic                   waiting_boundary;
        logic                   retry_pending;
        logic                   active;
    } t_res;

endpackage

// ===== rtl/prcr_cmd_if.sv =====
// Command request channel of the priority command reschedule controller.
// Depends on prcr_pkg for the payload type.
interface prcr_cmd_if;
    logic          valid;
    logic          ready;
    prcr_pkg::t_cmd payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/prcr_res_if.sv =====
// Result channel of the priority command reschedule controller.
// Depends on prcr_pkg for the payload type.
interface prcr_res_if;
    logic          valid;
    logic          ready;
    prcr_pkg::t_res payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/priority_command_reschedule_fsm_top.sv =====
// Top level of the priority command reschedule controller.
// Depends on prcr_pkg, prcr_cmd_if and prcr_res_if.
//
// Usage:
//   i_cmd carries one command request per valid/ready handshake; o_res returns
//   exactly one result per request, in order. Configuration is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data (index 0 gateway enable, index 1 attempt
//   limit) while no request is in flight.
// Decode and throughput:
//   A request is decoded against the controller state in the cycle it is
//   accepted; its result enters the output register in the cycle after. One
//   request per cycle is accepted, set by the single output register:
//   i_cmd.ready is high whenever that register is empty or being taken in
//   the same cycle.
// Reset:
//   Synchronous, active low. The controller returns to idle, the gateway is
//   disabled, the attempt limit is 3 and the generation counter is zero.
// Stall:
//   While o_res.ready is low and a result is held, i_cmd.ready drops and the
//   held result stays stable; no request is lost or repeated.
module priority_command_reschedule_fsm_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [prcr_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx,
    input  logic [prcr_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    prcr_cmd_if.sink                            i_cmd,
    prcr_res_if.source                          o_res
);

    logic                                r_gateway;
    logic [7:0]                          r_max_attempts;

    prcr_pkg::t_phase                    r_phase, n_phase;
    logic [prcr_pkg::TAG_BITS-1:0]       r_owner, n_owner;
    logic [prcr_pkg::SERIAL_BITS-1:0]    r_claim_gen, n_claim_gen;
    logic [prcr_pkg::SERIAL_BITS-1:0]    r_gen_src, n_gen_src;
    logic [prcr_pkg::SERIAL_BITS-1:0]    r_cutoff, n_cutoff;
    logic [7:0]                          r_attempts, n_attempts;

    logic                                r_out_valid;
    prcr_pkg::t_res                      r_out, n_out;

    logic                                accept;
    logic                                run_attempt;
    logic                                later;
    logic [prcr_pkg::SERIAL_BITS-1:0]    gen_inc;
    logic [prcr_pkg::SERIAL_BITS-1:0]    serial_diff;
    logic [7:0]                          attempts_inc;
    prcr_pkg::t_cmd                      cmd;

    assign cmd         = i_cmd.payload;
    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    assign gen_inc      = r_gen_src + 32'd1;
    assign serial_diff  = cmd.cutoff_serial - r_cutoff;
    assign later        = (cmd.cutoff_serial != '0) && (r_cutoff != '0) &&
                          (cmd.cutoff_serial != r_cutoff) &&
                          (serial_diff < prcr_pkg::SERIAL_HALF);
    assign attempts_inc = (r_attempts < prcr_pkg::ATTEMPT_SAT) ? r_attempts + 8'd1
                                                                : r_attempts;

    always_comb begin
        n_phase     = r_phase;
        n_owner     = r_owner;
        n_claim_gen = r_claim_gen;
        n_gen_src   = r_gen_src;
        n_cutoff    = r_cutoff;
        n_attempts  = r_attempts;
        run_attempt = 1'b0;
        n_out       = '0;
        n_out.status = prcr_pkg::ST_INVALID;

        if (r_gateway) begin
            case (cmd.command)
                prcr_pkg::CMD_REQUEST: begin
                    if (cmd.work_tag != '0) begin
                        if (r_phase != prcr_pkg::PH_IDLE) begin
                            if (cmd.work_tag != r_owner) begin
                                n_out.status = prcr_pkg::ST_BUSY;
                            end else begin
                                if (r_phase == prcr_pkg::PH_BOUNDARY &&
                                    (r_cutoff == '0 || later)) begin
                                    n_cutoff = cmd.cutoff_serial;
                                end
                                n_out.status = prcr_pkg::ST_ACCEPTED;
                            end
                        end else begin
                            n_out.abort_request = 1'b1;
                            n_gen_src   = (gen_inc == '0) ? 32'd1 : gen_inc;
                            n_owner     = cmd.work_tag;
                            n_claim_gen = n_gen_src;
                            n_cutoff    = cmd.cutoff_serial;
                            n_attempts  = '0;
                            n_phase     = prcr_pkg::PH_BOUNDARY;
                            n_out.status = prcr_pkg::ST_ACCEPTED;
                        end
                    end
                end
                prcr_pkg::CMD_BOUNDARY: begin
                    run_attempt = (r_phase == prcr_pkg::PH_BOUNDARY);
                end
                prcr_pkg::CMD_RETRY: begin
                    run_attempt = (r_phase == prcr_pkg::PH_RETRY);
                end
                default: begin
                    run_attempt = 1'b0;
                end
            endcase
        end

        if (run_attempt) begin
            n_out.reschedule_issued = 1'b1;
            n_attempts = attempts_inc;
            if (cmd.schedule_outcome == prcr_pkg::OUTCOME_SUCCESS) begin
                n_phase     = prcr_pkg::PH_IDLE;
                n_owner     = '0;
                n_claim_gen = '0;
                n_cutoff    = '0;
                n_attempts  = '0;
                n_out.status = prcr_pkg::ST_SCHEDULED;
            end else if (cmd.schedule_outcome == prcr_pkg::OUTCOME_RETRYABLE &&
                         attempts_inc < r_max_attempts) begin
                n_phase      = prcr_pkg::PH_RETRY;
                n_out.status = prcr_pkg::ST_RETRY;
            end else begin
                n_out.failure_valid      = 1'b1;
                n_out.failure_generation = r_claim_gen;
                n_out.failure_cutoff     = r_cutoff;
                n_out.abort_clear        = 1'b1;
                n_phase     = prcr_pkg::PH_IDLE;
                n_owner     = '0;
                n_claim_gen = '0;
                n_cutoff    = '0;
                n_attempts  = '0;
                n_out.status = prcr_pkg::ST_FAILED;
            end
        end

        n_out.waiting_boundary = (n_phase == prcr_pkg::PH_BOUNDARY);
        n_out.retry_pending    = (n_phase == prcr_pkg::PH_RETRY);
        n_out.active           = (n_phase != prcr_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gateway      <= 1'b0;
            r_max_attempts <= prcr_pkg::MAX_ATTEMPTS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                prcr_pkg::CFG_GATEWAY_ENABLED:       r_gateway      <= i_cfg_data[0];
                prcr_pkg::CFG_MAX_SCHEDULE_ATTEMPTS: r_max_attempts <= i_cfg_data;
                default: begin
                    r_gateway <= r_gateway;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= prcr_pkg::PH_IDLE;
            r_owner     <= '0;
            r_claim_gen <= '0;
            r_gen_src   <= '0;
            r_cutoff    <= '0;
            r_attempts  <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_owner     <= n_owner;
            r_claim_gen <= n_claim_gen;
            r_gen_src   <= n_gen_src;
            r_cutoff    <= n_cutoff;
            r_attempts  <= n_attempts;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== dv/tb_priority_command_reschedule_fsm_top.sv =====
// Testbench for the priority command reschedule controller: directed and random command
// requests under varied handshake pressure, checked against a cycle-free claim predictor.
// Depends on prcr_pkg, prcr_cmd_if, prcr_res_if and priority_command_reschedule_fsm_top.
module tb_priority_command_reschedule_fsm_top;
    import prcr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_TARGET = 1800;
    localparam int PHASE_ITEMS = 230;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] OUTCOME_FATAL = 2'd2;
    localparam logic [1:0] OUTCOME_OTHER = 2'd3;

    class claim_tracker;
        bit                     gw_enabled;
        logic [7:0]             attempt_limit;
        t_phase                 state_phase;
        logic [TAG_BITS-1:0]    owner;
        logic [SERIAL_BITS-1:0] claim_gen;
        logic [SERIAL_BITS-1:0] gen_counter;
        logic [SERIAL_BITS-1:0] cutoff_held;
        logic [7:0]             attempts;
        t_res                   pending_results[$];
        int                     mismatches;
        int                     checked;

        function new();
            gw_enabled = 1'b0;
            attempt_limit = MAX_ATTEMPTS_RESET;
            gen_counter = '0;
            mismatches = 0;
            checked = 0;
            drop_claim();
        endfunction

        function void drop_claim();
            state_phase = PH_IDLE;
            owner = '0;
            claim_gen = '0;
            cutoff_held = '0;
            attempts = '0;
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] idx,
                                   logic [CFG_DATA_BITS-1:0] data);
            if (idx == CFG_GATEWAY_ENABLED) begin
                gw_enabled = data[0];
            end else if (idx == CFG_MAX_SCHEDULE_ATTEMPTS) begin
                attempt_limit = data;
            end
        endfunction

        function bit cutoff_is_newer(logic [SERIAL_BITS-1:0] cand,
                                     logic [SERIAL_BITS-1:0] base);
            logic [SERIAL_BITS-1:0] diff;
            diff = cand - base;
            return (cand != '0) && (base != '0) && (cand != base) && (diff < SERIAL_HALF);
        endfunction

        function void note_request(t_cmd c);
            t_res r;
            r = '0;
            r.status = ST_INVALID;
            if (gw_enabled) begin
                if (c.command == CMD_REQUEST) begin
                    if (c.work_tag != '0) begin
                        if (state_phase != PH_IDLE) begin
                            if (c.work_tag != owner) begin
                                r.status = ST_BUSY;
                            end else begin
                                if (state_phase == PH_BOUNDARY && (cutoff_held == '0 ||
                                        cutoff_is_newer(c.cutoff_serial, cutoff_held))) begin
                                    cutoff_held = c.cutoff_serial;
                                end
                                r.status = ST_ACCEPTED;
                            end
                        end else begin
                            r.abort_request = 1'b1;
                            gen_counter = gen_counter + 1;
                            if (gen_counter == '0) begin
                                gen_counter = 1;
                            end
                            owner = c.work_tag;
                            claim_gen = gen_counter;
                            cutoff_held = c.cutoff_serial;
                            attempts = '0;
                            state_phase = PH_BOUNDARY;
                            r.status = ST_ACCEPTED;
                        end
                    end
                end else if ((c.command == CMD_BOUNDARY && state_phase == PH_BOUNDARY) ||
                             (c.command == CMD_RETRY && state_phase == PH_RETRY)) begin
                    r.reschedule_issued = 1'b1;
                    if (attempts != ATTEMPT_SAT) begin
                        attempts = attempts + 1;
                    end
                    if (c.schedule_outcome == OUTCOME_SUCCESS) begin
                        drop_claim();
                        r.status = ST_SCHEDULED;
                    end else if (c.schedule_outcome == OUTCOME_RETRYABLE &&
                                 attempts < attempt_limit) begin
                        state_phase = PH_RETRY;
                        r.status = ST_RETRY;
                    end else begin
                        r.failure_valid = 1'b1;
                        r.failure_generation = claim_gen;
                        r.failure_cutoff = cutoff_held;
                        drop_claim();
                        r.abort_clear = 1'b1;
                        r.status = ST_FAILED;
                    end
                end
            end
            r.waiting_boundary = (state_phase == PH_BOUNDARY);
            r.retry_pending = (state_phase == PH_RETRY);
            r.active = (state_phase != PH_IDLE);
            pending_results.push_back(r);
        endfunction

        function string field_diff(string name, logic [31:0] e, logic [31:0] g);
            if (g === e) begin
                return "";
            end
            return $sformatf(" %s exp %0h got %0h", name, e, g);
        endfunction

        function void check_result(t_res got);
            t_res e;
            string diffs;
            checked++;
            if (pending_results.size() == 0) begin
                diffs = $sformatf(" no result expected, got %p", got);
            end else begin
                e = pending_results.pop_front();
                diffs = {field_diff("status", e.status, got.status),
                         field_diff("abort_request", e.abort_request, got.abort_request),
                         field_diff("abort_clear", e.abort_clear, got.abort_clear),
                         field_diff("reschedule_issued", e.reschedule_issued,
                                    got.reschedule_issued),
                         field_diff("failure_valid", e.failure_valid, got.failure_valid),
                         field_diff("failure_generation", e.failure_generation,
                                    got.failure_generation),
                         field_diff("failure_cutoff", e.failure_cutoff, got.failure_cutoff),
                         field_diff("waiting_boundary", e.waiting_boundary,
                                    got.waiting_boundary),
                         field_diff("retry_pending", e.retry_pending, got.retry_pending),
                         field_diff("active", e.active, got.active)};
            end
            if (diffs != "") begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch on result %0d:%s", checked, diffs);
                end
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    prcr_cmd_if cmd_ch();
    prcr_res_if res_ch();

    priority_command_reschedule_fsm_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    claim_tracker tracker = new();
    int send_idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int random_items = 0;
    int settings_applied = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                tracker.check_result(res_ch.payload);
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                tracker.note_request(cmd_ch.payload);
            end
            if ((res_ch.valid && res_ch.ready) || (cmd_ch.valid && cmd_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
                $display("tb_priority_command_reschedule_fsm_top NOT OK");
                $finish;
            end
        end
    end

    task automatic send_cmd(logic [1:0] command, logic [TAG_BITS-1:0] tag,
                            logic [SERIAL_BITS-1:0] cutoff, logic [1:0] outcome);
        t_cmd c;
        c.command = command;
        c.work_tag = tag;
        c.cutoff_serial = cutoff;
        c.schedule_outcome = outcome;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.payload <= c;
        do @(posedge i_clk); while (!cmd_ch.ready);
        items_sent++;
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.set_register(idx, data);
        @(posedge i_clk);
    endtask

    task automatic apply_setting(bit gw, logic [7:0] limit);
        settle();
        write_reg(CFG_GATEWAY_ENABLED, {7'd0, gw});
        write_reg(CFG_MAX_SCHEDULE_ATTEMPTS, limit);
        settings_applied++;
    endtask

    task automatic send_noise();
        send_cmd(2'($urandom_range(3)), TAG_BITS'($urandom), $urandom, 2'($urandom_range(3)));
    endtask

    function automatic logic [TAG_BITS-1:0] pick_tag();
        int r;
        r = $urandom_range(19);
        if (r < 10) return TAG_BITS'($urandom_range(1, 4));
        if (r < 17) return TAG_BITS'($urandom);
        if (r < 19) return '1;
        return '0;
    endfunction

    function automatic logic [1:0] pick_outcome();
        int r;
        r = $urandom_range(99);
        if (r < 25) return OUTCOME_SUCCESS;
        if (r < 88) return OUTCOME_RETRYABLE;
        if (r < 95) return OUTCOME_FATAL;
        return OUTCOME_OTHER;
    endfunction

    task automatic run_claim_sequence();
        logic [TAG_BITS-1:0]    tag;
        logic [SERIAL_BITS-1:0] base;
        logic [1:0]             cmd;
        logic [1:0]             outc;
        int                     tries;
        tag = pick_tag();
        base = $urandom;
        send_cmd(CMD_REQUEST, tag, ($urandom_range(9) == 0) ? '0 : base, 2'($urandom_range(3)));
        repeat ($urandom_range(0, 3)) begin
            case ($urandom_range(3))
                0: send_cmd(CMD_REQUEST, tag, base + $urandom_range(0, 8) - 4, OUTCOME_SUCCESS);
                1: send_cmd(CMD_REQUEST, tag ^ (TAG_BITS'(1) << $urandom_range(TAG_BITS - 1)),
                            $urandom, OUTCOME_SUCCESS);
                2: send_cmd(CMD_REQUEST, tag, $urandom, 2'($urandom_range(3)));
                default: send_cmd(CMD_REQUEST, tag, base + SERIAL_HALF + $urandom_range(0, 4) - 2,
                                  OUTCOME_SUCCESS);
            endcase
        end
        cmd = CMD_BOUNDARY;
        tries = 0;
        for (int k = 0; k < 300; k++) begin
            if ($urandom_range(19) == 0) begin
                send_cmd((cmd == CMD_BOUNDARY) ? CMD_RETRY : CMD_BOUNDARY, tag, $urandom,
                         OUTCOME_SUCCESS);
            end
            if ($urandom_range(9) == 0) begin
                send_cmd(CMD_REQUEST, tag, $urandom, OUTCOME_SUCCESS);
            end
            outc = pick_outcome();
            send_cmd(cmd, TAG_BITS'($urandom), $urandom, outc);
            tries++;
            if (outc != OUTCOME_RETRYABLE || tries >= tracker.attempt_limit) break;
            cmd = CMD_RETRY;
        end
    endtask

    task automatic run_directed();
        send_cmd(CMD_REQUEST, 16'h0005, 32'd10, OUTCOME_SUCCESS);
        send_cmd(CMD_BOUNDARY, 16'h0005, 32'd0, OUTCOME_SUCCESS);
        apply_setting(1'b1, 8'd3);
        send_cmd(CMD_REQUEST, '0, 32'd1, OUTCOME_SUCCESS);
        send_cmd(CMD_BOUNDARY, 16'h0001, '0, OUTCOME_SUCCESS);
        send_cmd(CMD_RETRY, 16'h0001, '0, OUTCOME_SUCCESS);
        send_cmd(CMD_UNUSED, '1, '1, OUTCOME_OTHER);
        send_cmd(CMD_REQUEST, '1, '0, OUTCOME_SUCCESS);
        send_cmd(CMD_REQUEST, 16'h1234, 32'd50, OUTCOME_SUCCESS);
        send_cmd(CMD_REQUEST, '1, 32'd100, OUTCOME_SUCCESS);
        send_cmd(CMD_REQUEST, '1, 32'd100, OUTCOME_SUCCESS);
        send_cmd(CMD_REQUEST, '1, 32'h8000_0064, OUTCOME_SUCCESS);
        send_cmd(CMD_REQUEST, '1, '0, OUTCOME_SUCCESS);
        send_cmd(CMD_REQUEST, '1, 32'd101, OUTCOME_SUCCESS);
        send_cmd(CMD_RETRY, '1, '0, OUTCOME_SUCCESS);
        send_cmd(CMD_BOUNDARY, '1, '0, OUTCOME_RETRYABLE);
        send_cmd(CMD_REQUEST, '1, 32'd500, OUTCOME_SUCCESS);
        send_cmd(CMD_BOUNDARY, '1, '0, OUTCOME_SUCCESS);
        send_cmd(CMD_RETRY, '1, '0, OUTCOME_RETRYABLE);
        send_cmd(CMD_RETRY, '1, '0, OUTCOME_RETRYABLE);
        send_cmd(CMD_REQUEST, 16'h0001, '1, OUTCOME_SUCCESS);
        send_cmd(CMD_BOUNDARY, 16'h0001, '0, OUTCOME_SUCCESS);
        send_cmd(CMD_REQUEST, 16'h0002, 32'd7, OUTCOME_SUCCESS);
        send_cmd(CMD_BOUNDARY, 16'h0002, '0, OUTCOME_FATAL);
        send_cmd(CMD_REQUEST, 16'h0003, 32'd8, OUTCOME_SUCCESS);
        send_cmd(CMD_BOUNDARY, 16'h0003, '0, OUTCOME_OTHER);
        apply_setting(1'b1, 8'd0);
        send_cmd(CMD_REQUEST, 16'h8000, 32'h7FFF_FFFF, OUTCOME_SUCCESS);
        send_cmd(CMD_BOUNDARY, 16'h8000, '0, OUTCOME_RETRYABLE);
    endtask

    task automatic run_random();
        int start;
        for (int p = 0; random_items < RANDOM_TARGET; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 6; stall_pct = 6; end
            endcase
            if (p % 6 == 3) begin
                apply_setting(1'b0, 8'($urandom));
                repeat (30) send_noise();
            end
            case (p % 6)
                0: apply_setting(1'b1, 8'd3);
                1: apply_setting(1'b1, 8'd1);
                2: apply_setting(1'b1, 8'd255);
                3: apply_setting(1'b1, 8'd0);
                4: apply_setting(1'b1, 8'($urandom_range(2, 20)));
                default: apply_setting(1'b1, 8'd2);
            endcase
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                if ($urandom_range(99) < 15) begin
                    send_noise();
                end else begin
                    run_claim_sequence();
                end
                if ($urandom_range(99) < 2) begin
                    settle();
                end
            end
            random_items += items_sent - start;
        end
    endtask

    initial begin
        int failures;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.payload <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        settle();
        repeat (3) @(posedge i_clk);
        failures = tracker.mismatches + tracker.pending_results.size();
        if (tracker.pending_results.size() != 0) begin
            $display("%0d results never arrived", tracker.pending_results.size());
        end
        $display("sent %0d command requests over %0d register settings and four handshake mixes",
                 items_sent, settings_applied);
        $display("checked %0d results, %0d mismatches", tracker.checked, tracker.mismatches);
        if (failures == 0) begin
            $display("tb_priority_command_reschedule_fsm_top OK");
        end else begin
            $display("tb_priority_command_reschedule_fsm_top NOT OK");
        end
        $finish;
    end
endmodule
